// ===== sv/rbi_pkg.sv =====
// Shared types and constants for the ray versus box intersection block.
// Used by rbi_frac_div and ray_box_intersect; no dependencies.
package rbi_pkg;

    localparam int CW         = 32;
    localparam int FRAC       = 16;
    localparam int QW         = FRAC + 1;
    localparam int DIV_STAGES = FRAC + 1;
    localparam int IDXW       = 3;
    localparam int NUM_REGS   = 6;

    localparam logic [IDXW-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDXW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDXW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDXW-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDXW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDXW-1:0] REG_MAX_Z = 3'd5;

    localparam logic [2:0] FACE_NONE   = 3'd0;
    localparam logic [2:0] FACE_INSIDE = 3'd1;
    localparam logic [2:0] FACE_NEG_X  = 3'd2;

    typedef enum logic [1:0] {
        CLS_INSIDE,
        CLS_BELOW,
        CLS_ABOVE
    } cls_t;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] step_x;
        logic signed [CW-1:0] step_y;
        logic signed [CW-1:0] step_z;
    } ray_t;

    typedef struct packed {
        logic          hit;
        logic [QW-1:0] hit_param;
        logic [2:0]    face_code;
    } result_t;

endpackage

// ===== sv/rbi_frac_div.sv =====
// Pipelined restoring fractional divider: quot = floor(num * 2^FRAC / den).
// One quotient bit per stage; needs num <= den. Depends on rbi_pkg.
module rbi_frac_div (
    input  logic                    clk,
    input  logic [rbi_pkg::CW-1:0]  num,
    input  logic [rbi_pkg::CW-1:0]  den,
    output logic [rbi_pkg::QW-1:0]  quot
);

    localparam int CW = rbi_pkg::CW;
    localparam int QW = rbi_pkg::QW;
    localparam int NS = rbi_pkg::DIV_STAGES;

    logic [CW-1:0] rem_reg  [NS];
    logic [CW-1:0] rem_next [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [QW-1:0] quo_next [NS];
    logic [CW-1:0] den_reg  [NS];

    always_comb
    begin
        logic [CW:0] shifted;
        if (num >= den)
        begin
            rem_next[0] = num - den;
            quo_next[0] = QW'(1);
        end
        else
        begin
            rem_next[0] = num;
            quo_next[0] = '0;
        end
        for (int k = 1; k < NS; k++)
        begin
            shifted = {rem_reg[k-1], 1'b0};
            if (shifted >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = CW'(shifted - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[CW-1:0];
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int k = 1; k < NS; k++)
        begin
            den_reg[k] <= den_reg[k-1];
        end
        for (int k = 0; k < NS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign quot = quo_reg[NS-1];

endmodule

// ===== sv/ray_box_intersect.sv =====
// Ray segment versus axis-aligned box test, fully pipelined.
// Depends on rbi_pkg and rbi_frac_div.
//
// One transaction is accepted every cycle (busy never rises) and its result appears
// with result_valid after the capture, classify, bit-per-stage divider, pick, scale and
// result stages. The result is shown for a single cycle and must be taken then.
// The box registers are written through the cfg port, which is always ready; write them
// only while no transaction is in flight.
module ray_box_intersect (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rbi_pkg::ray_t                 ray,
    output logic                          result_valid,
    output rbi_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbi_pkg::IDXW-1:0]      cfg_index,
    input  logic [rbi_pkg::CW-1:0]        cfg_data
);

    localparam int CW = rbi_pkg::CW;
    localparam int QW = rbi_pkg::QW;
    localparam int FRAC = rbi_pkg::FRAC;
    localparam int NS = rbi_pkg::DIV_STAGES;

    logic signed [CW-1:0] box_reg [rbi_pkg::NUM_REGS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbi_pkg::NUM_REGS; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_index < rbi_pkg::IDXW'(rbi_pkg::NUM_REGS))
        begin
            box_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
    assign lo[0] = box_reg[rbi_pkg::REG_MIN_X];
    assign lo[1] = box_reg[rbi_pkg::REG_MIN_Y];
    assign lo[2] = box_reg[rbi_pkg::REG_MIN_Z];
    assign hi[0] = box_reg[rbi_pkg::REG_MAX_X];
    assign hi[1] = box_reg[rbi_pkg::REG_MAX_Y];
    assign hi[2] = box_reg[rbi_pkg::REG_MAX_Z];

    // stage A: capture
    logic                 a_valid_reg;
    logic signed [CW-1:0] a_org_reg [3];
    logic signed [CW-1:0] a_stp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_org_reg[0] <= ray.origin_x;
        a_org_reg[1] <= ray.origin_y;
        a_org_reg[2] <= ray.origin_z;
        a_stp_reg[0] <= ray.step_x;
        a_stp_reg[1] <= ray.step_y;
        a_stp_reg[2] <= ray.step_z;
    end

    // stage B: classify
    rbi_pkg::cls_t        b_cls_next [3];
    logic [2:0]           b_rej_next;
    logic [CW-1:0]        b_num_next [3];
    logic [CW-1:0]        b_den_next [3];
    logic                 b_valid_reg;
    rbi_pkg::cls_t        b_cls_reg [3];
    logic                 b_rej_reg;
    logic [CW-1:0]        b_num_reg [3];
    logic [CW-1:0]        b_den_reg [3];
    logic signed [CW-1:0] b_org_reg [3];
    logic signed [CW-1:0] b_stp_reg [3];

    always_comb
    begin
        logic signed [CW:0] o_e;
        logic signed [CW:0] s_e;
        logic signed [CW:0] d_lo;
        logic signed [CW:0] d_hi;
        logic signed [CW:0] neg_s;
        for (int a = 0; a < 3; a++)
        begin
            o_e   = (CW+1)'(a_org_reg[a]);
            s_e   = (CW+1)'(a_stp_reg[a]);
            d_lo  = (CW+1)'(lo[a]) - o_e;
            d_hi  = o_e - (CW+1)'(hi[a]);
            neg_s = -s_e;
            if (a_org_reg[a] < lo[a])
            begin
                b_cls_next[a] = rbi_pkg::CLS_BELOW;
                b_rej_next[a] = d_lo > s_e;
                b_num_next[a] = d_lo[CW-1:0];
                b_den_next[a] = s_e[CW-1:0];
            end
            else if (a_org_reg[a] > hi[a])
            begin
                b_cls_next[a] = rbi_pkg::CLS_ABOVE;
                b_rej_next[a] = d_hi > neg_s;
                b_num_next[a] = d_hi[CW-1:0];
                b_den_next[a] = neg_s[CW-1:0];
            end
            else
            begin
                b_cls_next[a] = rbi_pkg::CLS_INSIDE;
                b_rej_next[a] = 1'b0;
                b_num_next[a] = '0;
                b_den_next[a] = CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_rej_reg <= |b_rej_next;
        for (int a = 0; a < 3; a++)
        begin
            b_cls_reg[a] <= b_cls_next[a];
            b_num_reg[a] <= b_num_next[a];
            b_den_reg[a] <= b_den_next[a];
            b_org_reg[a] <= a_org_reg[a];
            b_stp_reg[a] <= a_stp_reg[a];
        end
    end

    // divide stages
    logic [QW-1:0] div_t [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        rbi_frac_div u_div (
            .clk  (clk),
            .num  (b_num_reg[a]),
            .den  (b_den_reg[a]),
            .quot (div_t[a])
        );
    end

    logic                 dl_valid_reg [NS];
    logic                 dl_rej_reg   [NS];
    rbi_pkg::cls_t        dl_cls_reg   [NS][3];
    logic signed [CW-1:0] dl_org_reg   [NS][3];
    logic signed [CW-1:0] dl_stp_reg   [NS][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                dl_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            dl_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k < NS; k++)
            begin
                dl_valid_reg[k] <= dl_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_rej_reg[0] <= b_rej_reg;
        for (int a = 0; a < 3; a++)
        begin
            dl_cls_reg[0][a] <= b_cls_reg[a];
            dl_org_reg[0][a] <= b_org_reg[a];
            dl_stp_reg[0][a] <= b_stp_reg[a];
        end
        for (int k = 1; k < NS; k++)
        begin
            dl_rej_reg[k] <= dl_rej_reg[k-1];
            for (int a = 0; a < 3; a++)
            begin
                dl_cls_reg[k][a] <= dl_cls_reg[k-1][a];
                dl_org_reg[k][a] <= dl_org_reg[k-1][a];
                dl_stp_reg[k][a] <= dl_stp_reg[k-1][a];
            end
        end
    end

    // stage C: pick the farthest front face
    logic [1:0]           c_best_next;
    logic [QW-1:0]        c_t_next;
    logic                 c_any_next;
    logic                 c_valid_reg;
    logic                 c_rej_reg;
    logic                 c_inside_reg;
    logic [1:0]           c_best_reg;
    logic                 c_above_reg;
    logic [QW-1:0]        c_t_reg;
    logic signed [CW-1:0] c_org_reg [3];
    logic signed [CW-1:0] c_stp_reg [3];

    always_comb
    begin
        c_best_next = '0;
        c_t_next    = '0;
        c_any_next  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (dl_cls_reg[NS-1][a] != rbi_pkg::CLS_INSIDE)
            begin
                if (!c_any_next || div_t[a] > c_t_next)
                begin
                    c_best_next = 2'(a);
                    c_t_next    = div_t[a];
                end
                c_any_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= dl_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_rej_reg    <= dl_rej_reg[NS-1];
        c_inside_reg <= !c_any_next;
        c_best_reg   <= c_best_next;
        c_above_reg  <= dl_cls_reg[NS-1][c_best_next] == rbi_pkg::CLS_ABOVE;
        c_t_reg      <= c_t_next;
        for (int a = 0; a < 3; a++)
        begin
            c_org_reg[a] <= dl_org_reg[NS-1][a];
            c_stp_reg[a] <= dl_stp_reg[NS-1][a];
        end
    end

    // stage D: scale step by t
    logic                    d_valid_reg;
    logic                    d_rej_reg;
    logic                    d_inside_reg;
    logic [1:0]              d_best_reg;
    logic                    d_above_reg;
    logic [QW-1:0]           d_t_reg;
    logic [CW+QW-1:0]        d_prod_reg [3];
    logic                    d_neg_reg  [3];
    logic signed [CW-1:0]    d_org_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [CW:0] mag;
        d_rej_reg    <= c_rej_reg;
        d_inside_reg <= c_inside_reg;
        d_best_reg   <= c_best_reg;
        d_above_reg  <= c_above_reg;
        d_t_reg      <= c_t_reg;
        for (int a = 0; a < 3; a++)
        begin
            mag = (CW+1)'(c_stp_reg[a]);
            if (mag < 0)
            begin
                mag = -mag;
            end
            d_prod_reg[a] <= (CW+QW)'(mag[CW-1:0]) * (CW+QW)'(c_t_reg);
            d_neg_reg[a]  <= c_stp_reg[a] < 0;
            d_org_reg[a]  <= c_org_reg[a];
        end
    end

    // stage E: slab checks and result
    rbi_pkg::result_t result_next;
    rbi_pkg::result_t result_reg;
    logic             result_valid_reg;

    always_comb
    begin
        logic signed [CW+1:0] p;
        logic signed [CW+1:0] ofs;
        logic                 ok;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            ofs = (CW+2)'(d_prod_reg[a][CW+QW-1:FRAC]);
            p   = d_neg_reg[a] ? (CW+2)'(d_org_reg[a]) - ofs : (CW+2)'(d_org_reg[a]) + ofs;
            if (2'(a) != d_best_reg && (p < (CW+2)'(lo[a]) || p > (CW+2)'(hi[a])))
            begin
                ok = 1'b0;
            end
        end
        result_next = '0;
        result_next.face_code = rbi_pkg::FACE_NONE;
        if (d_rej_reg)
        begin
            result_next.hit = 1'b0;
        end
        else if (d_inside_reg)
        begin
            result_next.hit       = 1'b1;
            result_next.face_code = rbi_pkg::FACE_INSIDE;
        end
        else if (ok)
        begin
            result_next.hit       = 1'b1;
            result_next.hit_param = d_t_reg;
            result_next.face_code = rbi_pkg::FACE_NEG_X + {d_best_reg, 1'b0}
                                    + {2'b00, d_above_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== verif/tb_ray_box_intersect.sv =====
// Testbench for ray_box_intersect: directed and random ray segments against several boxes.
// Self-checking against an in-bench fixed-point slab predictor; depends on rbi_pkg.
module tb_ray_box_intersect;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW      = rbi_pkg::CW;
    localparam int QW      = rbi_pkg::QW;
    localparam int FRAC    = rbi_pkg::FRAC;
    localparam int IDXW    = rbi_pkg::IDXW;
    localparam int LATENCY = rbi_pkg::DIV_STAGES + 5;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    rbi_pkg::ray_t    ray = '0;
    logic             result_valid;
    rbi_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDXW-1:0]  cfg_index = '0;
    logic [CW-1:0]    cfg_data = '0;

    ray_box_intersect dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .ray(ray),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    logic signed [CW-1:0] box_lo [3];
    logic signed [CW-1:0] box_hi [3];
    rbi_pkg::ray_t    pending_rays [$];
    rbi_pkg::result_t expected_hits [$];
    int      errors = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    logic    cfg_busy = 1'b0;
    logic [IDXW-1:0] cfg_idx_q [$];
    logic [CW-1:0]   cfg_val_q [$];

    function automatic logic [QW-1:0] face_dist(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = num;
        if (r >= den)
        begin
            q = 1;
            r -= den;
        end
        for (int i = 0; i < FRAC; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        return q[QW-1:0];
    endfunction

    function automatic longint scale_step(longint a, longint t);
        return (a >>> FRAC) * t + (((a & ((64'sd1 << FRAC) - 1)) * t) >>> FRAC);
    endfunction

    function automatic rbi_pkg::result_t predict_hit(rbi_pkg::ray_t r);
        longint o [3];
        longint s [3];
        longint lo;
        longint hi;
        longint d;
        longint p;
        longint t [3];
        rbi_pkg::cls_t cls [3];
        longint best_t;
        int     best;
        logic   in_box;
        rbi_pkg::result_t res;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        s[0] = r.step_x;   s[1] = r.step_y;   s[2] = r.step_z;
        res = '0;
        in_box = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            lo = box_lo[a];
            hi = box_hi[a];
            t[a] = 0;
            cls[a] = rbi_pkg::CLS_INSIDE;
            if (o[a] < lo)
            begin
                d = lo - o[a];
                if (d > s[a])
                    return res;
                t[a] = face_dist(d, s[a]);
                cls[a] = rbi_pkg::CLS_BELOW;
                in_box = 1'b0;
            end
            else if (o[a] > hi)
            begin
                d = hi - o[a];
                if (d < s[a])
                    return res;
                t[a] = face_dist(-d, -s[a]);
                cls[a] = rbi_pkg::CLS_ABOVE;
                in_box = 1'b0;
            end
        end
        if (in_box)
        begin
            res.hit = 1'b1;
            res.face_code = rbi_pkg::FACE_INSIDE;
            return res;
        end
        best = -1;
        best_t = 0;
        for (int a = 0; a < 3; a++)
            if (cls[a] != rbi_pkg::CLS_INSIDE && (best < 0 || t[a] > best_t))
            begin
                best = a;
                best_t = t[a];
            end
        for (int a = 0; a < 3; a++)
        begin
            if (a == best)
                continue;
            if (s[a] < 0)
                p = o[a] - scale_step(-s[a], best_t);
            else
                p = o[a] + scale_step(s[a], best_t);
            if (p < longint'(box_lo[a]) || p > longint'(box_hi[a]))
                return res;
        end
        res.hit = 1'b1;
        res.hit_param = best_t[QW-1:0];
        res.face_code = rbi_pkg::FACE_NEG_X + 3'(2 * best)
                        + ((cls[best] == rbi_pkg::CLS_ABOVE) ? 3'd1 : 3'd0);
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (start && !busy)
            expected_hits.push_back(predict_hit(ray));
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index < rbi_pkg::REG_MAX_X)
                box_lo[cfg_index] = cfg_data;
            else if (cfg_index < rbi_pkg::NUM_REGS)
                box_hi[cfg_index - rbi_pkg::REG_MAX_X] = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if (!(start && busy))
        begin
            if (pending_rays.size() > 0 && gap_left == 0)
            begin
                start <= 1'b1;
                ray <= pending_rays.pop_front();
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
                if (burst_left == 0 && gap_left == 0)
                    burst_left = $urandom_range(1, 40);
            end
            else
            begin
                start <= 1'b0;
                if (gap_left > 0 && burst_left == 0)
                    gap_left--;
                else if (gap_left > 0)
                    burst_left = 0;
            end
        end
        if (!(cfg_valid && !cfg_ready))
        begin
            if (cfg_idx_q.size() > 0)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_idx_q.pop_front();
                cfg_data <= cfg_val_q.pop_front();
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        rbi_pkg::result_t want;
        if (result_valid)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result %p", result);
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (result.hit !== want.hit)
                begin
                    $error("hit expected %0d actual %0d", want.hit, result.hit);
                    errors++;
                end
                if (result.hit_param !== want.hit_param)
                begin
                    $error("hit_param expected %0d actual %0d", want.hit_param,
                           result.hit_param);
                    errors++;
                end
                if (result.face_code !== want.face_code)
                begin
                    $error("face_code expected %0d actual %0d", want.face_code,
                           result.face_code);
                    errors++;
                end
            end
        end
    end

    task automatic write_box(logic signed [CW-1:0] lx, logic signed [CW-1:0] ly,
                             logic signed [CW-1:0] lz, logic signed [CW-1:0] hx,
                             logic signed [CW-1:0] hy, logic signed [CW-1:0] hz);
        cfg_idx_q = '{rbi_pkg::REG_MIN_X, rbi_pkg::REG_MIN_Y, rbi_pkg::REG_MIN_Z,
                      rbi_pkg::REG_MAX_X, rbi_pkg::REG_MAX_Y, rbi_pkg::REG_MAX_Z};
        cfg_val_q = '{lx, ly, lz, hx, hy, hz};
        wait (cfg_idx_q.size() == 0);
        @(posedge clk);
        while (cfg_valid)
            @(posedge clk);
    endtask

    task automatic drain();
        while (pending_rays.size() > 0 || start)
            @(posedge clk);
        while (expected_hits.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic add_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                           logic signed [CW-1:0] oz, logic signed [CW-1:0] sx,
                           logic signed [CW-1:0] sy, logic signed [CW-1:0] sz);
        rbi_pkg::ray_t r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.step_x = sx;   r.step_y = sy;   r.step_z = sz;
        pending_rays.push_back(r);
    endtask

    task automatic random_rays(int count, logic signed [CW-1:0] span);
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
                add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (mode < 3)
                add_ray(rand_coord(1), rand_coord(1), rand_coord(1),
                        rand_coord(1), rand_coord(1), rand_coord(1));
            else
                add_ray(-span - $signed($urandom_range(0, 3 << 16)),
                        rand_coord(1) / 4, rand_coord(1) / 4,
                        span * 2 + $signed($urandom_range(0, 6 << 16)),
                        rand_coord(1) / 2, rand_coord(1) / 2);
            if (mode >= 3 && $urandom_range(0, 1))
            begin
                rbi_pkg::ray_t r;
                r = pending_rays.pop_back();
                {r.origin_x, r.origin_y} = {r.origin_y, r.origin_x};
                {r.step_x, r.step_y} = {r.step_y, r.step_x};
                if ($urandom_range(0, 1))
                begin
                    r.origin_y = -r.origin_y;
                    r.step_y = -r.step_y;
                end
                pending_rays.push_back(r);
            end
        end
    endtask

    localparam logic signed [CW-1:0] ONE = 32'sd65536;
    localparam logic signed [CW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [CW-1:0] MINV = 32'sh80000000;

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(ONE, 0, 0, -2 * ONE, 0, 0);
        drain();
        write_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        add_ray(0, 0, 0, 5, 5, 5);
        add_ray(-2 * ONE, 0, 0, 4 * ONE, 0, 0);
        add_ray(2 * ONE, 0, 0, -4 * ONE, 0, 0);
        add_ray(0, -2 * ONE, 0, 0, 4 * ONE, 0);
        add_ray(0, 2 * ONE, 0, 0, -4 * ONE, 0);
        add_ray(0, 0, -2 * ONE, 0, 0, 4 * ONE);
        add_ray(0, 0, 2 * ONE, 0, 0, -4 * ONE);
        add_ray(-2 * ONE, 0, 0, 0, 0, 0);
        add_ray(-2 * ONE, 0, 0, ONE, 0, 0);
        add_ray(-2 * ONE, -2 * ONE, 0, 4 * ONE, 4 * ONE, 0);
        add_ray(-2 * ONE, 0, 0, ONE, ONE, 0);
        add_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV);
        add_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV);
        add_ray(MAXV, 0, 0, MINV, 0, 0);
        add_ray(-2 * ONE, 0, 0, 3 * ONE, 8 * ONE, 0);
        add_ray(ONE, ONE, ONE, -1, -1, -1);
        drain();
        write_box(MINV, MINV, MINV, MAXV, MAXV, MAXV);
        add_ray(MINV, MAXV, 0, 0, 0, 0);
        add_ray(MAXV, MINV, MAXV, MINV, MAXV, MINV);
        drain();
        write_box(ONE, 0, 0, -ONE, ONE, ONE);
        add_ray(0, 0, 0, 4 * ONE, 0, 0);
        add_ray(-4 * ONE, ONE / 2, ONE / 2, 8 * ONE, 0, 0);
        random_rays(50, ONE);
        drain();
        write_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        random_rays(400, ONE);
        drain();
        write_box(-3 * ONE, -ONE / 2, -5 * ONE, 2 * ONE, 4 * ONE, -ONE);
        random_rays(250, 3 * ONE);
        drain();
        write_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_rays(50, ONE);
        drain();
        write_box(-7 * ONE, -7 * ONE, -7 * ONE, 7 * ONE, 7 * ONE, 7 * ONE);
        random_rays(180, 7 * ONE);
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
